// ----- design/spam_pkg.sv -----
// Shared constants, types and codes of the sparse polynomial add/multiply unit.
package spam_pkg;

  localparam int unsigned MaxTerms    = 8;
  localparam int unsigned MaxExponent = 255;
  localparam int unsigned AccDepth    = 2 * MaxExponent + 1;

  localparam int unsigned CntW    = $clog2(MaxTerms + 1);
  localparam int unsigned IdxW    = (MaxTerms > 1) ? $clog2(MaxTerms) : 1;
  localparam int unsigned AddrW   = $clog2(AccDepth);
  localparam int unsigned CoefW   = 16;
  localparam int unsigned ExpW    = 8;
  localparam int unsigned ProdW   = 2 * CoefW;
  localparam int unsigned AccW    = 38;
  localparam int unsigned ResExpW = 9;

  localparam logic ModeAdd = 1'b0;
  localparam logic ModeMul = 1'b1;

  typedef struct packed {
    logic [ExpW-1:0]  expo;
    logic [CoefW-1:0] coef;
  } term_t;

  typedef struct packed {
    logic load;
    logic second;
    logic clear;
  } opnd_ctrl_t;

  typedef struct packed {
    logic [CntW-1:0] a_count;
    logic [CntW-1:0] b_count;
    logic            dropped;
  } opnd_status_t;

endpackage

// ----- design/spam_if.sv -----
// Channel interfaces of the sparse polynomial add/multiply unit.
interface spam_term_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 second_operand;
  logic signed [spam_pkg::CoefW-1:0]    coefficient;
  logic        [spam_pkg::ExpW-1:0]     exponent;
  logic                                 last_term;

  modport source (output valid, second_operand, coefficient, exponent, last_term,
                  input ready);
  modport sink (input valid, second_operand, coefficient, exponent, last_term,
                output ready);
endinterface

interface spam_result_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [spam_pkg::AccW-1:0]     result_coefficient;
  logic        [spam_pkg::ResExpW-1:0]  result_exponent;
  logic                                 last_result;
  logic                                 terms_dropped;

  modport source (output valid, result_coefficient, result_exponent, last_result,
                  terms_dropped, input ready);
  modport sink (input valid, result_coefficient, result_exponent, last_result,
                terms_dropped, output ready);
endinterface

interface spam_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- design/spam_operands.sv -----
// Operand term stores for polynomials A and B with fill counts and drop flag.
module spam_operands (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  spam_pkg::opnd_ctrl_t           ctrl_i,
  input  spam_pkg::term_t                in_term_i,
  input  logic [spam_pkg::IdxW-1:0]      a_idx_i,
  input  logic [spam_pkg::IdxW-1:0]      b_idx_i,
  output spam_pkg::term_t                a_term_o,
  output spam_pkg::term_t                b_term_o,
  output spam_pkg::opnd_status_t         status_o
);

  spam_pkg::term_t first_terms_q  [spam_pkg::MaxTerms];
  spam_pkg::term_t second_terms_q [spam_pkg::MaxTerms];

  logic [spam_pkg::CntW-1:0] a_cnt_q, a_cnt_d;
  logic [spam_pkg::CntW-1:0] b_cnt_q, b_cnt_d;
  logic                      ovf_q, ovf_d;

  logic in_range;
  logic a_room;
  logic b_room;
  logic store_a;
  logic store_b;

  assign in_range = (32'(in_term_i.expo) <= spam_pkg::MaxExponent);
  assign a_room   = (a_cnt_q < spam_pkg::CntW'(spam_pkg::MaxTerms));
  assign b_room   = (b_cnt_q < spam_pkg::CntW'(spam_pkg::MaxTerms));
  assign store_a  = ctrl_i.load && !ctrl_i.second && in_range && a_room;
  assign store_b  = ctrl_i.load && ctrl_i.second && in_range && b_room;

  always_comb begin
    a_cnt_d = a_cnt_q;
    b_cnt_d = b_cnt_q;
    ovf_d   = ovf_q;
    if (ctrl_i.clear) begin
      a_cnt_d = '0;
      b_cnt_d = '0;
      ovf_d   = 1'b0;
    end else if (ctrl_i.load) begin
      if (store_a) begin
        a_cnt_d = a_cnt_q + spam_pkg::CntW'(1);
      end
      if (store_b) begin
        b_cnt_d = b_cnt_q + spam_pkg::CntW'(1);
      end
      if (!store_a && !store_b) begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_cnt_q <= '0;
      b_cnt_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      a_cnt_q <= a_cnt_d;
      b_cnt_q <= b_cnt_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_a) begin
      first_terms_q[a_cnt_q[spam_pkg::IdxW-1:0]] <= in_term_i;
    end
    if (store_b) begin
      second_terms_q[b_cnt_q[spam_pkg::IdxW-1:0]] <= in_term_i;
    end
  end

  assign a_term_o         = first_terms_q[a_idx_i];
  assign b_term_o         = second_terms_q[b_idx_i];
  assign status_o.a_count = a_cnt_q;
  assign status_o.b_count = b_cnt_q;
  assign status_o.dropped = ovf_q;

endmodule

// ----- design/sparse_polynomial_add_multiply_unit.sv -----
// Top level of the sparse polynomial add/multiply unit.
// Terms load at one per cycle while the unit is in its load state. After the final B
// term the job runs its accumulations (|A|+|B| in add mode, |A|*|B| in multiply mode),
// then a descending scan of the 511-entry accumulator memory at one entry a cycle, which
// also zeroes it; output stalls hold the scan. After reset a clearing pass over all 511
// accumulator entries runs while no term is taken; mode resets to add.
module sparse_polynomial_add_multiply_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  spam_term_if.sink     term_i,
  spam_cfg_if.sink      cfg_i,
  spam_result_if.source result_o
);

  typedef enum logic [1:0] {ST_CLEAR, ST_LOAD, ST_ACCUM, ST_SCAN} state_e;

  localparam logic [spam_pkg::AddrW-1:0] LastAddr = spam_pkg::AddrW'(spam_pkg::AccDepth - 1);

  state_e state_q, state_d;
  logic   mode_q, mode_d;

  logic [spam_pkg::CntW-1:0]  i_q, i_d;
  logic [spam_pkg::CntW-1:0]  j_q, j_d;
  logic [spam_pkg::AddrW-1:0] clr_addr_q, clr_addr_d;
  logic [spam_pkg::AddrW-1:0] scan_addr_q, scan_addr_d;
  logic                       scan_more_q, scan_more_d;
  logic                       s_vld_q, s_vld_d;
  logic [spam_pkg::AddrW-1:0] s_addr_q;
  logic                       p_vld_q, p_vld_d;
  logic [spam_pkg::AddrW-1:0] p_addr_q;
  logic signed [spam_pkg::AccW-1:0] p_val_q;
  logic                       fwd_vld_q, fwd_vld_d;
  logic [spam_pkg::AddrW-1:0] fwd_addr_q;
  logic signed [spam_pkg::AccW-1:0] fwd_data_q;

  logic                       pend_vld_q, pend_vld_d;
  logic signed [spam_pkg::AccW-1:0] pend_coef_q;
  logic [spam_pkg::AddrW-1:0] pend_addr_q;

  logic                       out_vld_q, out_vld_d;
  logic signed [spam_pkg::AccW-1:0] out_coef_q, out_coef_d;
  logic [spam_pkg::ResExpW-1:0] out_exp_q, out_exp_d;
  logic                       out_last_q, out_last_d;
  logic                       out_drop_q, out_drop_d;

  // Accumulator memory, one entry per result exponent.
  logic signed [spam_pkg::AccW-1:0] acc_mem [spam_pkg::AccDepth];
  logic signed [spam_pkg::AccW-1:0] rdata_q;
  logic                             rd_en;
  logic [spam_pkg::AddrW-1:0]       rd_addr;
  logic                             wr_en;
  logic [spam_pkg::AddrW-1:0]       wr_addr;
  logic signed [spam_pkg::AccW-1:0] wr_data;

  spam_pkg::opnd_ctrl_t   op_ctrl;
  spam_pkg::opnd_status_t op_stat;
  spam_pkg::term_t        in_term;
  spam_pkg::term_t        a_term;
  spam_pkg::term_t        b_term;

  logic term_acc;
  logic job_start;
  logic a_more;
  logic b_more;
  logic iss;
  logic [spam_pkg::AddrW-1:0] iss_addr;
  logic signed [spam_pkg::AccW-1:0] iss_val;
  logic signed [spam_pkg::ProdW-1:0] prod;
  logic signed [spam_pkg::CoefW-1:0] add_coef;
  logic signed [spam_pkg::AccW-1:0] acc_base;
  logic signed [spam_pkg::AccW-1:0] acc_sum;
  logic acc_wr;
  logic nz;
  logic out_free;
  logic consume;
  logic scan_iss;
  logic finish;
  logic emit_prev;

  assign term_acc  = term_i.valid && term_i.ready;
  assign job_start = term_acc && term_i.second_operand && term_i.last_term;
  assign term_i.ready = (state_q == ST_LOAD);
  assign cfg_i.ready  = 1'b1;

  assign in_term.expo = term_i.exponent;
  assign in_term.coef = term_i.coefficient;
  assign op_ctrl.load   = term_acc;
  assign op_ctrl.second = term_i.second_operand;
  assign op_ctrl.clear  = finish;

  spam_operands u_operands (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (op_ctrl),
    .in_term_i (in_term),
    .a_idx_i   (i_q[spam_pkg::IdxW-1:0]),
    .b_idx_i   (j_q[spam_pkg::IdxW-1:0]),
    .a_term_o  (a_term),
    .b_term_o  (b_term),
    .status_o  (op_stat)
  );

  // Term and product issue.
  assign a_more   = (i_q < op_stat.a_count);
  assign b_more   = (j_q < op_stat.b_count);
  assign prod     = $signed(a_term.coef) * $signed(b_term.coef);
  assign add_coef = a_more ? $signed(a_term.coef) : $signed(b_term.coef);

  always_comb begin
    if (mode_q == spam_pkg::ModeMul) begin
      iss      = (state_q == ST_ACCUM) && a_more && b_more;
      iss_addr = spam_pkg::AddrW'({1'b0, a_term.expo} + {1'b0, b_term.expo});
      iss_val  = spam_pkg::AccW'(prod);
    end else begin
      iss      = (state_q == ST_ACCUM) && (a_more || b_more);
      iss_addr = spam_pkg::AddrW'(a_more ? a_term.expo : b_term.expo);
      iss_val  = spam_pkg::AccW'(add_coef);
    end
  end

  // Read-modify-write stage with one-deep forwarding of the previous write.
  assign acc_wr   = p_vld_q;
  assign acc_base = (fwd_vld_q && (fwd_addr_q == p_addr_q)) ? fwd_data_q : rdata_q;
  assign acc_sum  = acc_base + p_val_q;

  // Descending scan; the last nonzero entry is held back so that it can be marked.
  assign nz        = (rdata_q != '0);
  assign out_free  = !out_vld_q || result_o.ready;
  assign consume   = s_vld_q && (!nz || !pend_vld_q || out_free);
  assign emit_prev = consume && nz && pend_vld_q;
  assign scan_iss  = (state_q == ST_SCAN) && scan_more_q && (!s_vld_q || consume);
  assign finish    = (state_q == ST_SCAN) && !scan_more_q && !s_vld_q && out_free;

  assign rd_en   = iss || scan_iss;
  assign rd_addr = (state_q == ST_SCAN) ? scan_addr_q : iss_addr;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = s_addr_q;
    wr_data = '0;
    priority if (state_q == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
    end else if (acc_wr) begin
      wr_en   = 1'b1;
      wr_addr = p_addr_q;
      wr_data = acc_sum;
    end else if (consume) begin
      wr_en   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= acc_mem[rd_addr];
    end
    if (wr_en) begin
      acc_mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    i_d         = i_q;
    j_d         = j_q;
    clr_addr_d  = clr_addr_q;
    scan_addr_d = scan_addr_q;
    scan_more_d = scan_more_q;
    s_vld_d     = s_vld_q;
    p_vld_d     = iss;
    fwd_vld_d   = acc_wr;
    pend_vld_d  = pend_vld_q;
    out_vld_d   = out_vld_q && !result_o.ready;
    out_coef_d  = out_coef_q;
    out_exp_d   = out_exp_q;
    out_last_d  = out_last_q;
    out_drop_d  = out_drop_q;

    if (cfg_i.valid) begin
      mode_d = cfg_i.data;
    end

    unique case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + spam_pkg::AddrW'(1);
        if (clr_addr_q == LastAddr) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (job_start) begin
          i_d     = '0;
          j_d     = '0;
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (iss) begin
          if (mode_q == spam_pkg::ModeMul) begin
            if ((j_q + spam_pkg::CntW'(1)) == op_stat.b_count) begin
              j_d = '0;
              i_d = i_q + spam_pkg::CntW'(1);
            end else begin
              j_d = j_q + spam_pkg::CntW'(1);
            end
          end else if (a_more) begin
            i_d = i_q + spam_pkg::CntW'(1);
          end else begin
            j_d = j_q + spam_pkg::CntW'(1);
          end
        end else begin
          scan_addr_d = LastAddr;
          scan_more_d = 1'b1;
          s_vld_d     = 1'b0;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (consume) begin
          s_vld_d = 1'b0;
          if (nz) begin
            pend_vld_d = 1'b1;
          end
        end
        if (scan_iss) begin
          s_vld_d = 1'b1;
          if (scan_addr_q == '0) begin
            scan_more_d = 1'b0;
          end else begin
            scan_addr_d = scan_addr_q - spam_pkg::AddrW'(1);
          end
        end
        if (emit_prev) begin
          out_vld_d  = 1'b1;
          out_coef_d = pend_coef_q;
          out_exp_d  = spam_pkg::ResExpW'(pend_addr_q);
          out_last_d = 1'b0;
          out_drop_d = op_stat.dropped;
        end
        if (finish) begin
          out_vld_d  = 1'b1;
          out_coef_d = pend_vld_q ? pend_coef_q : '0;
          out_exp_d  = pend_vld_q ? spam_pkg::ResExpW'(pend_addr_q) : '0;
          out_last_d = 1'b1;
          out_drop_d = op_stat.dropped;
          pend_vld_d = 1'b0;
          state_d    = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      mode_q      <= spam_pkg::ModeAdd;
      i_q         <= '0;
      j_q         <= '0;
      clr_addr_q  <= '0;
      scan_addr_q <= '0;
      scan_more_q <= 1'b0;
      s_vld_q     <= 1'b0;
      p_vld_q     <= 1'b0;
      fwd_vld_q   <= 1'b0;
      pend_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
      out_coef_q  <= '0;
      out_exp_q   <= '0;
      out_last_q  <= 1'b0;
      out_drop_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      i_q         <= i_d;
      j_q         <= j_d;
      clr_addr_q  <= clr_addr_d;
      scan_addr_q <= scan_addr_d;
      scan_more_q <= scan_more_d;
      s_vld_q     <= s_vld_d;
      p_vld_q     <= p_vld_d;
      fwd_vld_q   <= fwd_vld_d;
      pend_vld_q  <= pend_vld_d;
      out_vld_q   <= out_vld_d;
      out_coef_q  <= out_coef_d;
      out_exp_q   <= out_exp_d;
      out_last_q  <= out_last_d;
      out_drop_q  <= out_drop_d;
    end
  end

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (iss) begin
      p_addr_q <= iss_addr;
      p_val_q  <= iss_val;
    end
    if (acc_wr) begin
      fwd_addr_q <= p_addr_q;
      fwd_data_q <= acc_sum;
    end
    if (scan_iss) begin
      s_addr_q <= scan_addr_q;
    end
    if (consume && nz) begin
      pend_coef_q <= rdata_q;
      pend_addr_q <= s_addr_q;
    end
  end

  assign result_o.valid              = out_vld_q;
  assign result_o.result_coefficient = out_coef_q;
  assign result_o.result_exponent    = out_exp_q;
  assign result_o.last_result        = out_last_q;
  assign result_o.terms_dropped      = out_drop_q;

  // An accumulation write only happens in the accumulate phase.
  a_acc_wr_in_accum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_wr |-> (state_q == ST_ACCUM))
    else $error("accumulation write outside the accumulate phase");

  // The scan never starts with an accumulation still in flight.
  a_scan_no_rmw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !p_vld_q)
    else $error("read-modify-write pending during the scan");

  // Leaving the scan clears the operand stores for the next job.
  a_job_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (op_stat.a_count == '0) && (op_stat.b_count == '0) && !op_stat.dropped)
    else $error("operand state not cleared after a job");

  // A new result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_prev || finish) |-> out_free)
    else $error("result register overwritten before its transfer");

endmodule
